### design/mnm_pkg.sv
// shared constants for the mutual nearest match block
`timescale 1ns / 1ps

package mnm_pkg;

  // default sizes
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int SCORE_BITS_DEF = 16;

  // fixed field widths
  localparam int SIZE_W    = 11;
  localparam int THR_W     = 16;
  localparam int KP_W      = 10;
  localparam int PARTNER_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_THRESHOLD = 2'd2;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0] ROWS_USED_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] COLS_USED_RST = 11'd1024;
  localparam logic signed [THR_W-1:0] LOG_THRESHOLD_RST = -16'sd412;

  // partner code for no match
  localparam logic signed [PARTNER_W-1:0] PARTNER_NONE = -11'sd1;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // query sides
  localparam logic SIDE_ROW = 1'b0;
  localparam logic SIDE_COL = 1'b1;

endpackage

### design/mnm_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module mnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/mutual_nearest_match.sv
// mutual nearest match: top level with row/column best tables and query logic
//
// Input channel (in_valid / in_stall) carries two kinds of request. A load
// request (in_cmd = 0) streams the next element of the (m+1) x (n+1) score
// matrix in row-major order; the dustbin row and column are skipped. A query
// request (in_cmd = 1) asks for the partner of keypoint in_query_index of
// image in_side and produces one result on the out_ channel.
// Loads are taken one per cycle while no query is in progress and produce
// no result: each load into the grid reads the column table at accept and
// may write it back the next cycle. A query passes through states Q1 and Q2
// (two dependent reads of the row and column tables); its result is registered
// at the end of Q2, then the next request is taken. If the receiver stalls, the
// result holds and the query waits in its last state; loads already taken still
// finish. The user must write configuration (cfg_we / cfg_index / cfg_wdata)
// only while idle; the block itself does not enforce this. Writing rows_used
// or cols_used restarts loading at element (0,0). Reset (synchronous, rst_n
// low) restores the register defaults, clears the load position and marks no
// matrix loaded; the tables need no clearing.
`timescale 1ns / 1ps

module mutual_nearest_match #(
  parameter int MAX_ROWS   = mnm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mnm_pkg::MAX_COLS_DEF,
  parameter int SCORE_BITS = mnm_pkg::SCORE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [mnm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mnm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // requests
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic signed [SCORE_BITS-1:0]          in_score,
  input  logic                                  in_side,
  input  logic [mnm_pkg::KP_W-1:0]              in_query_index,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_side_out,
  output logic [mnm_pkg::KP_W-1:0]              out_keypoint_index,
  output logic signed [mnm_pkg::PARTNER_W-1:0]  out_partner_index,
  output logic signed [SCORE_BITS-1:0]          out_log_score,
  output logic                                  out_mutual,
  output logic                                  out_valid_res,
  output logic                                  out_load_done
);

  localparam int RA_W  = $clog2(MAX_ROWS);
  localparam int CA_W  = $clog2(MAX_COLS);
  localparam int M_W   = $clog2(MAX_ROWS + 1);
  localparam int N_W   = $clog2(MAX_COLS + 1);
  localparam int IDX_W = (RA_W > CA_W) ? RA_W : CA_W;
  localparam int ROW_W = SCORE_BITS + CA_W;
  localparam int COL_W = SCORE_BITS + RA_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_Q1   = 2'd1;
  localparam logic [1:0] ST_Q2   = 2'd2;

  // configuration registers
  logic [mnm_pkg::SIZE_W-1:0]       rows_used_r;
  logic [mnm_pkg::SIZE_W-1:0]       cols_used_r;
  logic signed [mnm_pkg::THR_W-1:0] log_thr_r;

  // load position and running row maximum
  logic [M_W-1:0]               load_row_r, load_row_nxt;
  logic [N_W-1:0]               load_col_r, load_col_nxt;
  logic                         loaded_r, loaded_nxt;
  logic signed [SCORE_BITS-1:0] run_max_r, run_max_nxt;
  logic [CA_W-1:0]              run_arg_r, run_arg_nxt;

  // column read-modify-write stage
  logic                         ldp_v_r;
  logic signed [SCORE_BITS-1:0] ldp_s_r;
  logic [CA_W-1:0]              ldp_c_r;
  logic [RA_W-1:0]              ldp_row_r;
  logic                         ldp_first_r;

  // query state
  logic [1:0]                   st_r, st_nxt;
  logic                         q_side_r;
  logic [mnm_pkg::KP_W-1:0]     q_idx_r;
  logic                         q_inr_r;
  logic signed [SCORE_BITS-1:0] a_score_r;
  logic [IDX_W-1:0]             a_idx_r;
  logic                         a_ok_r;

  // output register
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_side_r;
  logic [mnm_pkg::KP_W-1:0]             out_kp_r;
  logic signed [mnm_pkg::PARTNER_W-1:0] out_partner_r;
  logic signed [SCORE_BITS-1:0]         out_score_r;
  logic                                 out_mutual_r;
  logic                                 out_vres_r;
  logic                                 out_done_r;

  // ram ports
  logic              row_we, row_re, col_we, col_re;
  logic [RA_W-1:0]   row_waddr, row_raddr;
  logic [CA_W-1:0]   col_waddr, col_raddr;
  logic [ROW_W-1:0]  row_wdata, row_rdata;
  logic [COL_W-1:0]  col_wdata, col_rdata;

  // clamped sizes
  logic [31:0]    rows_ext, cols_ext;
  logic [M_W-1:0] m_sz;
  logic [N_W-1:0] n_sz;

  logic in_acc, ld_acc, q_acc;
  logic in_grid, at_dust;
  logic out_free;

  logic signed [SCORE_BITS-1:0] col_old_score;
  logic [RA_W-1:0]              col_old_row;
  logic signed [SCORE_BITS-1:0] row_rd_score;
  logic [CA_W-1:0]              row_rd_col;
  logic [31:0]                  back_idx;
  logic                         res_mutual, res_valid;
  logic signed [31:0]           res_score_ext, thr_ext;

  assign rows_ext = 32'(rows_used_r);
  assign cols_ext = 32'(cols_used_r);

  always_comb begin
    if (rows_ext == 32'd0) begin
      m_sz = M_W'(1);
    end else if (rows_ext > 32'(MAX_ROWS)) begin
      m_sz = M_W'(MAX_ROWS);
    end else begin
      m_sz = M_W'(rows_ext);
    end
    if (cols_ext == 32'd0) begin
      n_sz = N_W'(1);
    end else if (cols_ext > 32'(MAX_COLS)) begin
      n_sz = N_W'(MAX_COLS);
    end else begin
      n_sz = N_W'(cols_ext);
    end
  end

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ld_acc   = in_acc && (in_cmd == mnm_pkg::CMD_LOAD);
  assign q_acc    = in_acc && (in_cmd == mnm_pkg::CMD_QUERY);
  assign out_free = !out_valid_r || !out_stall;

  assign in_grid = (load_row_r < m_sz) && (32'(load_col_r) < 32'(n_sz));
  assign at_dust = (load_row_r < m_sz) && (load_col_r == n_sz);

  // load sequencing and running row maximum
  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    loaded_nxt   = loaded_r;
    run_max_nxt  = run_max_r;
    run_arg_nxt  = run_arg_r;
    if (ld_acc) begin
      if (load_row_r == '0 && load_col_r == '0) begin
        loaded_nxt = 1'b0;
      end
      if (in_grid && (load_col_r == '0 || in_score > run_max_r)) begin
        run_max_nxt = in_score;
        run_arg_nxt = CA_W'(load_col_r);
      end
      if (load_col_r >= n_sz) begin
        load_col_nxt = '0;
        if (load_row_r >= m_sz) begin
          load_row_nxt = '0;
          loaded_nxt   = 1'b1;
        end else begin
          load_row_nxt = load_row_r + M_W'(1);
        end
      end else begin
        load_col_nxt = load_col_r + N_W'(1);
      end
    end
    // a size write restarts the load at element (0,0)
    if (cfg_we && (cfg_index inside {mnm_pkg::CFG_ROWS_USED, mnm_pkg::CFG_COLS_USED})) begin
      load_row_nxt = '0;
      load_col_nxt = '0;
      loaded_nxt   = 1'b0;
    end
  end

  // row table: written at the dustbin column, read by queries
  assign row_we       = ld_acc && at_dust;
  assign row_waddr    = RA_W'(load_row_r);
  assign row_wdata    = {run_max_r, run_arg_r};
  assign row_rd_score = row_rdata[ROW_W-1 -: SCORE_BITS];
  assign row_rd_col   = row_rdata[CA_W-1:0];

  // column table: read at load accept, written back the next cycle if the row is the first or the score is higher
  assign col_old_score = col_rdata[COL_W-1 -: SCORE_BITS];
  assign col_old_row   = col_rdata[RA_W-1:0];
  assign col_we        = ldp_v_r && (ldp_first_r || ldp_s_r > col_old_score);
  assign col_waddr     = ldp_c_r;
  assign col_wdata     = {ldp_s_r, ldp_row_r};

  // read address selection; a query's second read follows the first result
  always_comb begin
    row_re    = 1'b0;
    row_raddr = RA_W'(in_query_index);
    col_re    = 1'b0;
    col_raddr = CA_W'(in_query_index);
    if (st_r == ST_Q1) begin
      if (q_side_r == mnm_pkg::SIDE_ROW) begin
        col_re    = 1'b1;
        col_raddr = CA_W'(row_rd_col);
      end else begin
        row_re    = 1'b1;
        row_raddr = RA_W'(col_old_row);
      end
    end else if (ld_acc && in_grid) begin
      col_re    = 1'b1;
      col_raddr = CA_W'(load_col_r);
    end else if (q_acc) begin
      if (in_side == mnm_pkg::SIDE_ROW) begin
        row_re = 1'b1;
      end else begin
        col_re = 1'b1;
      end
    end
  end

  // result of the back-pointer check
  assign back_idx = (q_side_r == mnm_pkg::SIDE_ROW) ? 32'(col_old_row) : 32'(row_rd_col);
  assign res_mutual = loaded_r && q_inr_r && a_ok_r && (back_idx == 32'(q_idx_r));
  assign res_score_ext = 32'(a_score_r);
  assign thr_ext       = 32'(log_thr_r);
  assign res_valid     = res_mutual && (res_score_ext > thr_ext);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_acc) begin
          st_nxt = ST_Q1;
        end
      end
      ST_Q1: st_nxt = ST_Q2;
      ST_Q2: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (st_r == ST_Q2 && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= mnm_pkg::ROWS_USED_RST;
      cols_used_r <= mnm_pkg::COLS_USED_RST;
      log_thr_r   <= mnm_pkg::LOG_THRESHOLD_RST;
      load_row_r  <= '0;
      load_col_r  <= '0;
      loaded_r    <= 1'b0;
      ldp_v_r     <= 1'b0;
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      loaded_r    <= loaded_nxt;
      ldp_v_r     <= ld_acc && in_grid;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mnm_pkg::CFG_ROWS_USED: begin
            rows_used_r <= cfg_wdata[mnm_pkg::SIZE_W-1:0];
          end
          mnm_pkg::CFG_COLS_USED: begin
            cols_used_r <= cfg_wdata[mnm_pkg::SIZE_W-1:0];
          end
          mnm_pkg::CFG_LOG_THRESHOLD: begin
            log_thr_r <= cfg_wdata[mnm_pkg::THR_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_max_r   <= run_max_nxt;
    run_arg_r   <= run_arg_nxt;
    ldp_s_r     <= in_score;
    ldp_c_r     <= CA_W'(load_col_r);
    ldp_row_r   <= RA_W'(load_row_r);
    ldp_first_r <= (load_row_r == '0);
    if (q_acc) begin
      q_side_r <= in_side;
      q_idx_r  <= in_query_index;
      if (in_side == mnm_pkg::SIDE_ROW) begin
        q_inr_r <= 32'(in_query_index) < 32'(m_sz);
      end else begin
        q_inr_r <= 32'(in_query_index) < 32'(n_sz);
      end
    end
    if (st_r == ST_Q1) begin
      if (q_side_r == mnm_pkg::SIDE_ROW) begin
        a_score_r <= row_rd_score;
        a_idx_r   <= IDX_W'(row_rd_col);
        a_ok_r    <= 32'(row_rd_col) < 32'(n_sz);
      end else begin
        a_score_r <= col_old_score;
        a_idx_r   <= IDX_W'(col_old_row);
        a_ok_r    <= 32'(col_old_row) < 32'(m_sz);
      end
    end
    if (st_r == ST_Q2 && out_free) begin
      out_side_r    <= q_side_r;
      out_kp_r      <= q_idx_r;
      out_partner_r <= res_valid ? mnm_pkg::PARTNER_W'(a_idx_r) : mnm_pkg::PARTNER_NONE;
      out_score_r   <= res_mutual ? a_score_r : '0;
      out_mutual_r  <= res_mutual;
      out_vres_r    <= res_valid;
      out_done_r    <= loaded_r;
    end
  end

  mnm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_en   (row_re),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  mnm_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (col_waddr),
    .wr_data (col_wdata),
    .rd_en   (col_re),
    .rd_addr (col_raddr),
    .rd_data (col_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_side_out       = out_side_r;
  assign out_keypoint_index = out_kp_r;
  assign out_partner_index  = out_partner_r;
  assign out_log_score      = out_score_r;
  assign out_mutual         = out_mutual_r;
  assign out_valid_res      = out_vres_r;
  assign out_load_done      = out_done_r;

  // a query request always enters the two-read sequence
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_acc |=> (st_r == ST_Q1))
    else $error("query request did not start the table reads");

  // a new result is only produced at the end of a query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_Q2))
    else $error("result appeared without a query");

  // valid match implies mutual and a loaded matrix
  a_valid_mutual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_vres_r || (out_mutual_r && out_done_r)))
    else $error("valid match without mutual choice on a loaded matrix");

  // rejected matches carry no partner
  a_no_partner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vres_r) |-> (out_partner_r == mnm_pkg::PARTNER_NONE))
    else $error("partner reported for a rejected match");

  // column write-back only follows a load into the grid
  a_col_wb: assert property (@(posedge clk) disable iff (!rst_n)
    col_we |-> $past(ld_acc && in_grid))
    else $error("column table written without a load");

endmodule
